>>> hdl/klr_pkg.sv
// Shared types, key codes and the layer-two remap table for the keyboard layer remapper.
// No dependencies.
`timescale 1ns / 1ps

package klr_pkg;

	localparam logic [7:0]  KEY_SPACE      = 8'h20;
	localparam logic [7:0]  KEY_BACKSPACE  = 8'h08;
	localparam logic [15:0] WINDOW_RESET   = 16'd200;

	// Index of the final result within a run
	localparam logic [1:0]  LAST_IDX_PASS  = 2'd0;
	localparam logic [1:0]  LAST_IDX_MAP   = 2'd1;
	localparam logic [1:0]  LAST_IDX_TAP   = 2'd3;

	typedef enum logic [1:0] {
		RUN_PASS = 2'd0,
		RUN_MAP  = 2'd1,
		RUN_TAP  = 2'd2
	} run_kind_t;

	// One decoded run of results for a single key request
	typedef struct packed {
		run_kind_t  kind;
		logic [7:0] code;
		logic [1:0] last_idx;
		logic       layer;
	} run_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} map_hit_t;

	function automatic map_hit_t map_lookup(input logic [7:0] key);
		map_hit_t r;
		r.hit  = 1'b1;
		r.code = 8'h00;
		unique case (key)
			8'h41:   r.code = 8'h28;
			8'h53:   r.code = 8'h25;
			8'h44:   r.code = 8'h26;
			8'h46:   r.code = 8'h27;
			8'h4A:   r.code = 8'h24;
			8'h4B:   r.code = 8'h23;
			8'h4C:   r.code = 8'h0D;
			8'hBA:   r.code = 8'h08;
			8'hC0:   r.code = 8'h08;
			default: r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/klr_decode.sv
// Classifies a key request against the layer state and holds that state.
// Depends on klr_pkg.
`timescale 1ns / 1ps

module klr_decode import klr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] window_ms,
	input  logic [7:0]  key_code,
	input  logic        is_release,
	input  logic [31:0] now_ms,
	input  logic        load,
	output run_t        run
);

	logic        layer_q;
	logic [31:0] last_space_q;
	logic [31:0] diff;
	logic        space_rel;
	logic        toggle;
	logic        store_time;
	map_hit_t    hit;

	assign space_rel  = is_release && (key_code == KEY_SPACE);
	assign diff       = now_ms - last_space_q;
	assign toggle     = space_rel && (diff < {16'd0, window_ms});
	assign store_time = space_rel && !toggle;
	assign hit        = map_lookup(key_code);

	always_comb begin
		run.kind     = RUN_PASS;
		run.code     = 8'h00;
		run.last_idx = LAST_IDX_PASS;
		run.layer    = layer_q ^ toggle;
		if (toggle) begin
			run.kind     = RUN_TAP;
			run.code     = KEY_BACKSPACE;
			run.last_idx = LAST_IDX_TAP;
		end else if (!space_rel && layer_q && !is_release && hit.hit) begin
			run.kind     = RUN_MAP;
			run.code     = hit.code;
			run.last_idx = LAST_IDX_MAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_q      <= 1'b0;
			last_space_q <= 32'd0;
		end else if (load) begin
			layer_q <= layer_q ^ toggle;
			if (store_time) begin
				last_space_q <= now_ms;
			end
		end
	end

endmodule

>>> hdl/klr_emit.sv
// Holds one decoded run and steps through its results on the output channel.
// Depends on klr_pkg.
`timescale 1ns / 1ps

module klr_emit import klr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       run_valid,
	input  run_t       run_in,
	output logic       run_load,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       action,
	output logic [7:0] out_key_code,
	output logic       out_release,
	output logic       second_layer,
	output logic       last_of_run
);

	run_t       run_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       take;
	logic       done;

	assign take     = busy_q && out_ready;
	assign done     = take && (idx_q == run_q.last_idx);
	assign run_load = run_valid && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (run_load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_load) begin
			run_q <= run_in;
		end
	end

	assign out_valid    = busy_q;
	assign action       = (run_q.kind != RUN_PASS);
	assign out_key_code = action ? run_q.code : 8'h00;
	assign out_release  = action && idx_q[0];
	assign second_layer = run_q.layer;
	assign last_of_run  = (idx_q == run_q.last_idx);

endmodule

>>> hdl/keyboard_layer_remapper.sv
// An accepted request passes the input register and then the run register before its
// first result shows; a stalled output channel can hold it in the input register.
// One request per cycle for single-result requests while the receiver takes every result;
// a run holds the output register until its last result is taken, and has at most four.
// Reset (arst_n low, asynchronous): layer 1, last space release time 0, window 200 ms,
// both channels empty. Top level; uses klr_pkg, klr_decode and klr_emit.
`timescale 1ns / 1ps

module keyboard_layer_remapper import klr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  key_code,
	input  logic        is_release,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        action,
	output logic [7:0]  out_key_code,
	output logic        out_release,
	output logic        second_layer,
	output logic        last_of_run
);

	logic [15:0] window_q;

	// Input register: one request waits here while the current run drains
	logic        valid_s1;
	logic [7:0]  key_code_s1;
	logic        is_release_s1;
	logic [31:0] now_ms_s1;

	run_t        run;
	logic        run_load;

	// Window register: the user must write it only while idle, so no hazard with decode; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// Accept a new request whenever the input register is empty or moves on
	assign in_ready = !valid_s1 || run_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_code_s1   <= key_code;
			is_release_s1 <= is_release;
			now_ms_s1     <= now_ms;
		end
	end

	// Decode against the current layer state; state advances when the run loads
	klr_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.window_ms  (window_q),
		.key_code   (key_code_s1),
		.is_release (is_release_s1),
		.now_ms     (now_ms_s1),
		.load       (run_load),
		.run        (run)
	);

	// Run register and result sequencer; a new run loads as the last result leaves
	klr_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_valid    (valid_s1),
		.run_in       (run),
		.run_load     (run_load),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.out_key_code (out_key_code),
		.out_release  (out_release),
		.second_layer (second_layer),
		.last_of_run  (last_of_run)
	);

endmodule

>>> hdl/klr_checker.sv
// Port-level checks for the keyboard layer remapper, bound to the top level.
// Depends on keyboard_layer_remapper.
`timescale 1ns / 1ps

module klr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       action,
	input logic [7:0] out_key_code,
	input logic       out_release,
	input logic       second_layer,
	input logic       last_of_run
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action)
			&& $stable(out_key_code) && $stable(out_release)
			&& $stable(second_layer) && $stable(last_of_run))
		else $error("result changed while stalled");

	// A pass result is always alone and carries no synthetic code
	a_pass_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !action |-> last_of_run && out_key_code == 8'h00 && !out_release)
		else $error("pass result malformed");

	// A run never breaks off: the next result follows at once
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && action
			&& out_key_code == $past(out_key_code) && out_release == !$past(out_release))
		else $error("run interrupted");

	// Every synthetic run ends on a release
	a_tap_ends_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action && last_of_run |-> out_release)
		else $error("synthetic run does not end on a release");

endmodule

bind keyboard_layer_remapper klr_checker u_klr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.action       (action),
	.out_key_code (out_key_code),
	.out_release  (out_release),
	.second_layer (second_layer),
	.last_of_run  (last_of_run)
);

>>> bench/tb.sv
// Self-checking bench for keyboard_layer_remapper: drives key requests, predicts the layer and
// remap behavior, and checks every result field. Depends on klr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
	import klr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [7:0]  code;
		logic        rel;
		logic [31:0] ms;
	} key_req_t;

	typedef struct packed {
		logic       action;
		logic [7:0] code;
		logic       rel;
		logic       layer;
		logic       last;
	} key_outcome_t;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Block inputs, all known from time zero
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic [7:0]  key_code = '0;
	logic        is_release = 1'b0;
	logic [31:0] now_ms = '0;
	logic        out_ready = 1'b0;

	logic        in_ready;
	logic        out_valid;
	logic        action;
	logic [7:0]  out_key_code;
	logic        out_release;
	logic        second_layer;
	logic        last_of_run;

	keyboard_layer_remapper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_code     (key_code),
		.is_release   (is_release),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.out_key_code (out_key_code),
		.out_release  (out_release),
		.second_layer (second_layer),
		.last_of_run  (last_of_run)
	);

	// Pending requests, expected results and the shadow state of the remapper
	key_req_t     pending_keys[$];
	key_outcome_t expected_outcomes[$];
	key_req_t     on_port;
	logic         shadow_layer_two = 1'b0;
	logic [31:0]  shadow_last_space = '0;
	logic [15:0]  shadow_window = WINDOW_RESET;

	// Knobs set by the stimulus process at the falling edge
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	logic         hold_kick = 1'b0;
	int unsigned  hold_left = 0;
	logic         rx_hold;
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;
	logic [31:0]  gen_ms = 32'd5000;

	// Layer-two remap table: {hit, mapped code}
	function automatic logic [8:0] layer_two_map(input logic [7:0] key);
		case (key)
			8'h41: return {1'b1, 8'h28};
			8'h53: return {1'b1, 8'h25};
			8'h44: return {1'b1, 8'h26};
			8'h46: return {1'b1, 8'h27};
			8'h4A: return {1'b1, 8'h24};
			8'h4B: return {1'b1, 8'h23};
			8'h4C: return {1'b1, 8'h0D};
			8'hBA: return {1'b1, 8'h08};
			8'hC0: return {1'b1, 8'h08};
			default: return 9'h000;
		endcase
	endfunction

	// Physical key at a given table slot, for stimulus
	function automatic logic [7:0] table_key(input int unsigned slot);
		case (slot)
			0: return 8'h41;
			1: return 8'h53;
			2: return 8'h44;
			3: return 8'h46;
			4: return 8'h4A;
			5: return 8'h4B;
			6: return 8'h4C;
			7: return 8'hBA;
			default: return 8'hC0;
		endcase
	endfunction

	function automatic key_outcome_t make_outcome(input logic act, input logic [7:0] code,
		input logic rel, input logic last);
		key_outcome_t o;
		o.action = act;
		o.code   = code;
		o.rel    = rel;
		o.layer  = shadow_layer_two;
		o.last   = last;
		return o;
	endfunction

	// Advance the shadow state by one accepted request and queue the results it causes
	task automatic predict_remap(input key_req_t r);
		logic [31:0] since_space;
		logic [8:0]  hit;
		since_space = r.ms - shadow_last_space;
		hit = layer_two_map(r.code);
		if (r.rel && r.code == KEY_SPACE) begin
			if (since_space < {16'd0, shadow_window}) begin
				// Double tap: flip the layer, replace the release by two backspace taps
				shadow_layer_two = !shadow_layer_two;
				expected_outcomes.push_back(make_outcome(1'b1, KEY_BACKSPACE, 1'b0, 1'b0));
				expected_outcomes.push_back(make_outcome(1'b1, KEY_BACKSPACE, 1'b1, 1'b0));
				expected_outcomes.push_back(make_outcome(1'b1, KEY_BACKSPACE, 1'b0, 1'b0));
				expected_outcomes.push_back(make_outcome(1'b1, KEY_BACKSPACE, 1'b1, 1'b1));
			end else begin
				shadow_last_space = r.ms;
				expected_outcomes.push_back(make_outcome(1'b0, 8'h00, 1'b0, 1'b1));
			end
		end else if (shadow_layer_two && !r.rel && hit[8]) begin
			// Table key press in layer two: tap the mapped code instead
			expected_outcomes.push_back(make_outcome(1'b1, hit[7:0], 1'b0, 1'b0));
			expected_outcomes.push_back(make_outcome(1'b1, hit[7:0], 1'b1, 1'b1));
		end else begin
			expected_outcomes.push_back(make_outcome(1'b0, 8'h00, 1'b0, 1'b1));
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Driver: present queued requests, hold them until accepted, idle at random
	always @(posedge clk) begin
		logic offer;
		if (arst_n) begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				predict_remap(on_port);
				offer = 1'b0;
			end
			if (!offer && pending_keys.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				on_port = pending_keys.pop_front();
				offer = 1'b1;
			end
			in_valid   <= offer;
			key_code   <= on_port.code;
			is_release <= on_port.rel;
			now_ms     <= on_port.ms;
		end
	end

	// Monitor: compare each accepted result with the oldest expectation, stall at random
	always @(posedge clk) begin
		key_outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected result", {31'd0, action}, 32'd0);
				end else begin
					want = expected_outcomes.pop_front();
					if (action !== want.action)
						report_mismatch("action", {31'd0, action}, {31'd0, want.action});
					if (out_key_code !== want.code)
						report_mismatch("out_key_code", {24'd0, out_key_code}, {24'd0, want.code});
					if (out_release !== want.rel)
						report_mismatch("out_release", {31'd0, out_release}, {31'd0, want.rel});
					if (second_layer !== want.layer)
						report_mismatch("second_layer", {31'd0, second_layer}, {31'd0, want.layer});
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", {31'd0, last_of_run}, {31'd0, want.last});
				end
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering meanwhile
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_kick) begin
			hold_left <= HOLD_CYCLES;
		end
	end
	assign rx_hold = (hold_left != 0);

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic queue_key(input logic [7:0] code, input logic rel, input logic [31:0] ms);
		key_req_t r;
		r.code = code;
		r.rel  = rel;
		r.ms   = ms;
		pending_keys.push_back(r);
	endtask

	// One random request: mostly well-formed typing around the double-tap window, some noise
	task automatic queue_random_key();
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99);
		span = 32'(shadow_window);
		if ($urandom_range(99) < 3)
			gen_ms = $urandom;
		if (pick < 30) begin
			// Space release close to or beyond the window
			if ($urandom_range(1))
				gen_ms = gen_ms + $urandom_range(span);
			else
				gen_ms = gen_ms + $urandom_range(3 * span + 5);
			queue_key(KEY_SPACE, 1'b1, gen_ms);
		end else if (pick < 60) begin
			gen_ms = gen_ms + $urandom_range(50);
			queue_key(table_key($urandom_range(8)), 1'b0, gen_ms);
		end else if (pick < 70) begin
			gen_ms = gen_ms + $urandom_range(50);
			queue_key(table_key($urandom_range(8)), 1'b1, gen_ms);
		end else if (pick < 80) begin
			gen_ms = gen_ms + $urandom_range(50);
			queue_key(KEY_SPACE, 1'b0, gen_ms);
		end else begin
			// Noise: any code, any direction, any time
			queue_key(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom);
		end
	endtask

	// Wait until the sender is empty and every expected result has come, then settle
	task automatic drain();
		while (pending_keys.size() != 0 || in_valid || expected_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the window register while the block is idle, and track it in the shadow copy
	task automatic write_window(input logic [15:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		shadow_window = value;
		@(negedge clk);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned send_pct,
		input int unsigned recv_pct);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) queue_random_key();
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset window of 200 ms
		queue_key(8'h41, 1'b0, 32'd10);           // layer one: table key passes
		queue_key(KEY_SPACE, 1'b1, 32'd1000);     // first release: store time
		queue_key(KEY_SPACE, 1'b1, 32'd1100);     // double tap: enter layer two
		for (int unsigned s = 0; s < 9; s++)
			queue_key(table_key(s), 1'b0, 32'd1110 + s);
		queue_key(8'h41, 1'b1, 32'd1120);         // table key release passes
		queue_key(KEY_SPACE, 1'b0, 32'd1130);     // space press passes
		queue_key(8'hFF, 1'b0, 32'd1135);
		queue_key(8'h00, 1'b1, 32'd1140);
		queue_key(KEY_SPACE, 1'b1, 32'd1150);     // still within window of the release at 1000: back to one
		queue_key(8'h41, 1'b0, 32'd1160);
		queue_key(KEY_SPACE, 1'b1, 32'hFFFF_FFF0); // store near the top of the count
		queue_key(KEY_SPACE, 1'b1, 32'h0000_0050); // wrapped difference 96: toggle
		queue_key(KEY_SPACE, 1'b1, 32'h0000_00B8); // difference exactly 200: store
		queue_key(KEY_SPACE, 1'b1, 32'h0000_017F); // difference 199: toggle
		queue_key(8'hC0, 1'b0, 32'h0000_0180);
		drain();

		// Random phases across register settings and idling patterns
		write_window(16'hFFFF);
		run_phase(40, 0, 0);
		write_window(16'd0);
		run_phase(40, 53, 0);
		write_window(16'd1);
		run_phase(40, 0, 53);
		write_window(16'($urandom_range(65535)));
		run_phase(40, 36, 36);

		// Back pressure: block the receiver long enough for the input side to stall
		write_window(WINDOW_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (30) queue_random_key();
		hold_kick = 1'b1;
		while (!rx_hold) @(negedge clk);
		hold_kick = 1'b0;
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/klr_pkg.sv
hdl/klr_decode.sv
hdl/klr_emit.sv
hdl/keyboard_layer_remapper.sv
hdl/klr_checker.sv
bench/tb.sv
